// ----- rtl/wavdac_pkg.sv -----
`timescale 1ns / 1ps

package wavdac_pkg;

    // Header layout
    localparam int HEADER_BYTES = 44;
    localparam int VOLUME_SHIFT = 3;

    localparam logic [5:0] HDR_LAST   = 6'(HEADER_BYTES - 1);
    localparam logic [5:0] IDX_RIFF   = 6'd3;
    localparam logic [5:0] IDX_WAVE   = 6'd11;
    localparam logic [5:0] IDX_FMT    = 6'd15;
    localparam logic [5:0] IDX_CHAN   = 6'd23;
    localparam logic [5:0] IDX_RATE   = 6'd27;
    localparam logic [5:0] IDX_BITS   = 6'd35;
    localparam logic [5:0] IDX_DATA   = 6'd39;
    localparam logic [5:0] IDX_DSIZE  = 6'd43;

    // Tags as they sit in the little-endian shifter
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Result kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RIFF     = 3'd1;
    localparam logic [2:0] ST_WAVE     = 3'd2;
    localparam logic [2:0] ST_FMT      = 3'd3;
    localparam logic [2:0] ST_DATA     = 3'd4;
    localparam logic [2:0] ST_CHANNELS = 3'd5;
    localparam logic [2:0] ST_BITS     = 3'd6;

    localparam logic [15:0] CH_MONO    = 16'd1;
    localparam logic [15:0] CH_STEREO  = 16'd2;
    localparam logic [15:0] DEPTH_8    = 16'd8;
    localparam logic [15:0] DEPTH_16   = 16'd16;
    localparam logic [15:0] SIGN_FLIP  = 16'h8000;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       file_start;
    } wav_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [11:0] dac_code;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
    } wav_result_t;

endpackage

// ----- rtl/wav_stream_to_dac_top.sv -----
`timescale 1ns / 1ps

// WAV byte stream to 12-bit DAC code converter.
// Input channel (item_valid / item_stall / item): one file byte per transfer,
// with file_start set on the first byte of a new file to restart parsing.
// Output channel (result_valid / result_stall / result): at most one result
// per input byte: a DAC sample, the accepted header (rate, channels, depth),
// an error with its status code, or the end-of-data marker.
// Each byte is handled by one pass of logic between the state registers and
// the result register, so a result appears in the cycle after its byte is
// taken, and one byte can be taken in every cycle while item_stall is low.
// A single result register decouples the two sides: while it holds a result
// that the receiver stalls, item_stall is raised and input is held off;
// otherwise a new byte is taken even as the previous result leaves.
// After reset all parsing state is clear and the next byte counts as header
// byte 0. After an error or the end of data, bytes are consumed without
// results until one arrives with file_start set.
module wav_stream_to_dac_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  wavdac_pkg::wav_item_t   item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output wavdac_pkg::wav_result_t result
);
    import wavdac_pkg::*;

    logic [5:0]  header_index_reg, header_index_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic [2:0]  tag_error_reg, tag_error_next;
    logic [15:0] channels_reg, channels_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] data_size_reg, data_size_next;
    logic [31:0] data_count_reg, data_count_next;
    logic [1:0]  frame_idx_reg, frame_idx_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic        halted_reg, halted_next;

    logic        result_valid_reg, result_valid_next;
    wav_result_t result_reg, result_next;

    logic        accept;
    logic        emit;
    wav_result_t res;

    // Working copies of state, cleared when a new file begins
    logic [5:0]  cur_index;
    logic [31:0] cur_shift;
    logic [2:0]  cur_tag_error;
    logic [15:0] cur_channels;
    logic [15:0] cur_bits;
    logic [31:0] cur_rate;
    logic [31:0] cur_size;
    logic [31:0] cur_count;
    logic [1:0]  cur_frame;
    logic [7:0]  cur_low;
    logic        cur_halted;
    logic [31:0] shifted;
    logic [15:0] raw16;

    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        cur_index     = item.file_start ? '0 : header_index_reg;
        cur_shift     = item.file_start ? '0 : field_shift_reg;
        cur_tag_error = item.file_start ? '0 : tag_error_reg;
        cur_channels  = item.file_start ? '0 : channels_reg;
        cur_bits      = item.file_start ? '0 : bits_reg;
        cur_rate      = item.file_start ? '0 : rate_reg;
        cur_size      = item.file_start ? '0 : data_size_reg;
        cur_count     = item.file_start ? '0 : data_count_reg;
        cur_frame     = item.file_start ? '0 : frame_idx_reg;
        cur_low       = item.file_start ? '0 : low_byte_reg;
        cur_halted    = item.file_start ? 1'b0 : halted_reg;
    end

    // Parse one byte: header shifter, tag checks, format checks, sample codes
    always_comb
    begin
        header_index_next = cur_index;
        field_shift_next  = cur_shift;
        tag_error_next    = cur_tag_error;
        channels_next     = cur_channels;
        bits_next         = cur_bits;
        rate_next         = cur_rate;
        data_size_next    = cur_size;
        data_count_next   = cur_count;
        frame_idx_next    = cur_frame;
        low_byte_next     = cur_low;
        halted_next       = cur_halted;
        emit              = 1'b0;
        res               = '0;
        shifted           = {item.file_byte, cur_shift[31:8]};
        raw16             = '0;

        if (cur_halted)
        begin
            emit = 1'b0;
        end
        else if (cur_index < 6'(HEADER_BYTES))
        begin
            field_shift_next  = shifted;
            header_index_next = cur_index + 6'd1;
            case (cur_index)
                IDX_RIFF:
                    if (shifted != TAG_RIFF && cur_tag_error == ST_OK)
                        tag_error_next = ST_RIFF;
                IDX_WAVE:
                    if (shifted != TAG_WAVE && cur_tag_error == ST_OK)
                        tag_error_next = ST_WAVE;
                IDX_FMT:
                    if (shifted != TAG_FMT && cur_tag_error == ST_OK)
                        tag_error_next = ST_FMT;
                IDX_CHAN:  channels_next = shifted[31:16];
                IDX_RATE:  rate_next     = shifted;
                IDX_BITS:  bits_next     = shifted[31:16];
                IDX_DATA:
                    if (shifted != TAG_DATA && cur_tag_error == ST_OK)
                        tag_error_next = ST_DATA;
                IDX_DSIZE: data_size_next = shifted;
                default: ;
            endcase
            if (cur_index == HDR_LAST)
            begin
                emit = 1'b1;
                if (tag_error_next != ST_OK)
                begin
                    halted_next = 1'b1;
                    res.kind    = KIND_ERROR;
                    res.status  = tag_error_next;
                end
                else
                begin
                    res.kind          = KIND_HEADER;
                    res.sample_rate   = rate_next;
                    res.channel_count = channels_next;
                    res.sample_bits   = bits_next;
                end
            end
        end
        else if (cur_count >= cur_size)
        begin
            emit        = 1'b1;
            halted_next = 1'b1;
            res.kind    = KIND_END;
        end
        else if (cur_count == '0 && !(cur_channels inside {CH_MONO, CH_STEREO}))
        begin
            emit        = 1'b1;
            halted_next = 1'b1;
            res.kind    = KIND_ERROR;
            res.status  = ST_CHANNELS;
        end
        else if (cur_count == '0 && !(cur_bits inside {DEPTH_8, DEPTH_16}))
        begin
            emit        = 1'b1;
            halted_next = 1'b1;
            res.kind    = KIND_ERROR;
            res.status  = ST_BITS;
        end
        else
        begin
            data_count_next = cur_count + 32'd1;
            res.kind        = KIND_SAMPLE;
            if (cur_channels == CH_MONO && cur_bits == DEPTH_8)
            begin
                emit         = 1'b1;
                res.dac_code = 12'((16'(item.file_byte) >> VOLUME_SHIFT) << 4);
            end
            else if (cur_channels == CH_MONO || cur_bits == DEPTH_8)
            begin
                // Two-byte frames: mono 16-bit or stereo 8-bit
                if (cur_frame == 2'd0)
                begin
                    low_byte_next  = item.file_byte;
                    frame_idx_next = 2'd1;
                end
                else
                begin
                    frame_idx_next = 2'd0;
                    emit           = 1'b1;
                    if (cur_channels == CH_MONO)
                    begin
                        raw16        = {item.file_byte, cur_low} ^ SIGN_FLIP;
                        res.dac_code = 12'(raw16 >> (VOLUME_SHIFT + 4));
                    end
                    else
                    begin
                        res.dac_code = 12'(16'(cur_low) >> VOLUME_SHIFT);
                    end
                end
            end
            else
            begin
                // Stereo 16-bit: hold left sample, skip right sample
                case (cur_frame)
                    2'd0:
                    begin
                        low_byte_next  = item.file_byte;
                        frame_idx_next = 2'd1;
                    end
                    2'd1:
                    begin
                        field_shift_next = {16'd0, item.file_byte, cur_low};
                        frame_idx_next   = 2'd2;
                    end
                    2'd2:
                    begin
                        frame_idx_next = 2'd3;
                    end
                    default:
                    begin
                        frame_idx_next = 2'd0;
                        emit           = 1'b1;
                        raw16          = cur_shift[15:0] ^ SIGN_FLIP;
                        res.dac_code   = 12'(raw16 >> VOLUME_SHIFT);
                    end
                endcase
            end
        end
    end

    // Load a new result, or drop the held one once it transfers
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (accept && emit)
        begin
            result_valid_next = 1'b1;
            result_next       = res;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg <= '0;
            field_shift_reg  <= '0;
            tag_error_reg    <= '0;
            channels_reg     <= '0;
            bits_reg         <= '0;
            rate_reg         <= '0;
            data_size_reg    <= '0;
            data_count_reg   <= '0;
            frame_idx_reg    <= '0;
            low_byte_reg     <= '0;
            halted_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                header_index_reg <= header_index_next;
                field_shift_reg  <= field_shift_next;
                tag_error_reg    <= tag_error_next;
                channels_reg     <= channels_next;
                bits_reg         <= bits_next;
                rate_reg         <= rate_next;
                data_size_reg    <= data_size_next;
                data_count_reg   <= data_count_next;
                frame_idx_reg    <= frame_idx_next;
                low_byte_reg     <= low_byte_next;
                halted_reg       <= halted_next;
            end
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A halted parser produces nothing until a new file starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && halted_reg && !item.file_start) |-> !emit)
        else $error("result produced while halted");

    // The header counter never runs past the header
    assert property (@(posedge clk) disable iff (!rst_n)
        header_index_reg <= 6'(HEADER_BYTES))
        else $error("header index out of range");

    // Frame positions beyond the second byte occur only for stereo 16-bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_idx_reg > 2'd1) |-> (channels_reg == CH_STEREO && bits_reg == DEPTH_16))
        else $error("frame index beyond format");

    // Only error results carry a status
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind != KIND_ERROR) |-> (result.status == ST_OK))
        else $error("status on non-error result");

    // A taken byte that yields a result shows up in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> result_valid)
        else $error("result lost");

endmodule
